>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked by i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bvp_pkg.sv
// ---------------------------------------------------------------------------
// bvp_pkg
// Breakpoint tables, field widths and stage payload types of the
// battery voltage to percent converter.
// ---------------------------------------------------------------------------
package bvp_pkg;

    localparam int TABLE_LEN       = 21;
    localparam int BREAKPOINTS_DEF = 21;
    localparam int IDX_W           = 5;
    localparam int CODE_W          = 16;
    localparam int PCT_W           = 7;
    localparam int DP_W            = 5;
    localparam int DX_W            = 8;
    localparam int PROD_W          = 13;
    localparam int QUO_W           = 5;
    localparam int PCT_MAX         = 100;
    localparam int DP_MAX          = 30;

    localparam logic [CODE_W-1:0] VOLT_TAB [TABLE_LEN] = '{
        16'h0C7A, 16'h0D53, 16'h0D6C, 16'h0D9A, 16'h0DE1, 16'h0E28, 16'h0E39,
        16'h0E5F, 16'h0EB6, 16'h0F12, 16'h0F1F, 16'h0F34, 16'h0F45, 16'h0F5E,
        16'h0FD3, 16'h0FD7, 16'h0FDF, 16'h0FE3, 16'h0FE8, 16'h0FEC, 16'h1072
    };

    localparam logic [PCT_W-1:0] PCT_TAB [TABLE_LEN] = '{
        7'd0,  7'd4,  7'd6,  7'd10, 7'd16, 7'd21, 7'd23,
        7'd26, 7'd35, 7'd46, 7'd48, 7'd51, 7'd53, 7'd57,
        7'd87, 7'd88, 7'd90, 7'd92, 7'd93, 7'd94, 7'd100
    };

    typedef struct packed {
        logic [PCT_W-1:0] base;
        logic [DP_W-1:0]  dp;
        logic [DX_W-1:0]  dv;
        logic [DX_W-1:0]  dx;
    } t_sel;

    typedef struct packed {
        logic [PCT_W-1:0]  base;
        logic [DX_W-1:0]   dv;
        logic [PROD_W-1:0] prod;
    } t_mul;

    typedef struct packed {
        logic [PCT_W-1:0]  base;
        logic [DX_W-1:0]   dv;
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_div;

endpackage

>>> sv/bvp_front.sv
// ---------------------------------------------------------------------------
// bvp_front
// Compare, segment select and multiply stages: yields the segment base
// percentage, the segment width and the scaled offset for the divider.
// ---------------------------------------------------------------------------
module bvp_front #(
    parameter int BREAKPOINTS = bvp_pkg::BREAKPOINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [bvp_pkg::CODE_W-1:0]  i_code,
    output logic                        o_rdy,
    output logic                        o_vld,
    output bvp_pkg::t_mul               o_data,
    input  logic                        i_rdy
);

    localparam int N_USED = (BREAKPOINTS < bvp_pkg::TABLE_LEN) ? BREAKPOINTS
                                                                : bvp_pkg::TABLE_LEN;

    logic                                r_s1_vld;
    logic [bvp_pkg::CODE_W-1:0]          r_s1_code;
    logic [bvp_pkg::TABLE_LEN-1:1]       r_s1_le;
    logic                                r_s1_below;
    logic [bvp_pkg::TABLE_LEN-1:1]       n_s1_le;

    logic                                r_s2_vld;
    bvp_pkg::t_sel                       r_s2;
    bvp_pkg::t_sel                       n_s2;

    logic                                r_s3_vld;
    bvp_pkg::t_mul                       r_s3;
    bvp_pkg::t_mul                       n_s3;

    logic                                s1_rdy;
    logic                                s2_rdy;
    logic                                s3_rdy;
    logic                                found;
    logic [bvp_pkg::IDX_W-1:0]           sel;
    logic [bvp_pkg::IDX_W-1:0]           sel_m1;

    assign s3_rdy = !r_s3_vld || i_rdy;
    assign s2_rdy = !r_s2_vld || s3_rdy;
    assign s1_rdy = !r_s1_vld || s2_rdy;
    assign o_rdy  = s1_rdy;
    assign o_vld  = r_s3_vld;
    assign o_data = r_s3;

    always_comb begin
        for (int k = 1; k < bvp_pkg::TABLE_LEN; k++) begin
            n_s1_le[k] = (k < N_USED) && (i_code <= bvp_pkg::VOLT_TAB[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_vld <= i_vld;
        end
        if (s1_rdy && i_vld) begin
            r_s1_code  <= i_code;
            r_s1_le    <= n_s1_le;
            r_s1_below <= i_code < bvp_pkg::VOLT_TAB[0];
        end
    end

    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int k = bvp_pkg::TABLE_LEN - 1; k >= 1; k--) begin
            if (r_s1_le[k]) begin
                found = 1'b1;
                sel   = bvp_pkg::IDX_W'(k);
            end
        end
        sel_m1 = sel - bvp_pkg::IDX_W'(1);
        if (r_s1_below) begin
            n_s2.base = '0;
            n_s2.dp   = '0;
            n_s2.dv   = bvp_pkg::DX_W'(1);
            n_s2.dx   = '0;
        end else if (!found) begin
            n_s2.base = bvp_pkg::PCT_TAB[N_USED-1];
            n_s2.dp   = '0;
            n_s2.dv   = bvp_pkg::DX_W'(1);
            n_s2.dx   = '0;
        end else begin
            n_s2.base = bvp_pkg::PCT_TAB[sel_m1];
            n_s2.dp   = bvp_pkg::DP_W'(bvp_pkg::PCT_TAB[sel] - bvp_pkg::PCT_TAB[sel_m1]);
            n_s2.dv   = bvp_pkg::DX_W'(bvp_pkg::VOLT_TAB[sel] - bvp_pkg::VOLT_TAB[sel_m1]);
            n_s2.dx   = bvp_pkg::DX_W'(r_s1_code - bvp_pkg::VOLT_TAB[sel_m1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
        if (s2_rdy && r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end

    always_comb begin
        n_s3.base = r_s2.base;
        n_s3.dv   = r_s2.dv;
        n_s3.prod = bvp_pkg::PROD_W'(r_s2.dp) * bvp_pkg::PROD_W'(r_s2.dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (s3_rdy) begin
            r_s3_vld <= r_s2_vld;
        end
        if (s3_rdy && r_s2_vld) begin
            r_s3 <= n_s3;
        end
    end

endmodule

>>> sv/bvp_div.sv
// ---------------------------------------------------------------------------
// bvp_div
// Pipelined restoring divider: one quotient bit per stage, scaled offset
// divided by the segment width.
// ---------------------------------------------------------------------------
module bvp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  bvp_pkg::t_mul               i_data,
    output logic                        o_rdy,
    output logic                        o_vld,
    output logic [bvp_pkg::PCT_W-1:0]   o_base,
    output logic [bvp_pkg::QUO_W-1:0]   o_quo,
    input  logic                        i_rdy
);

    localparam int NSTG = bvp_pkg::QUO_W;

    logic          r_vld  [NSTG];
    bvp_pkg::t_div r_stg  [NSTG];
    logic          stg_rdy[NSTG+1];
    logic          in_vld [NSTG];
    bvp_pkg::t_div in_stg [NSTG];
    bvp_pkg::t_div n_stg  [NSTG];

    assign stg_rdy[NSTG] = i_rdy;
    assign o_rdy         = stg_rdy[0];
    assign o_vld         = r_vld[NSTG-1];
    assign o_base        = r_stg[NSTG-1].base;
    assign o_quo         = r_stg[NSTG-1].quo;

    assign in_vld[0]      = i_vld;
    assign in_stg[0].base = i_data.base;
    assign in_stg[0].dv   = i_data.dv;
    assign in_stg[0].rem  = i_data.prod;
    assign in_stg[0].quo  = '0;

    for (genvar j = 0; j < NSTG; j++) begin : g_stage
        localparam int BIT = NSTG - 1 - j;

        logic [bvp_pkg::PROD_W-1:0] dvs;
        logic                       take;

        if (j > 0) begin : g_link
            assign in_vld[j] = r_vld[j-1];
            assign in_stg[j] = r_stg[j-1];
        end

        assign stg_rdy[j] = !r_vld[j] || stg_rdy[j+1];

        always_comb begin
            dvs            = bvp_pkg::PROD_W'(in_stg[j].dv) << BIT;
            take           = in_stg[j].rem >= dvs;
            n_stg[j].base  = in_stg[j].base;
            n_stg[j].dv    = in_stg[j].dv;
            n_stg[j].rem   = take ? (in_stg[j].rem - dvs) : in_stg[j].rem;
            n_stg[j].quo   = {in_stg[j].quo[bvp_pkg::QUO_W-2:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (stg_rdy[j]) begin
                r_vld[j] <= in_vld[j];
            end
            if (stg_rdy[j] && in_vld[j]) begin
                r_stg[j] <= n_stg[j];
            end
        end
    end

endmodule

>>> sv/battery_voltage_to_percent_core.sv
// ---------------------------------------------------------------------------
// battery_voltage_to_percent_core
// Converts a raw battery voltage code into a charge percentage by piecewise
// linear interpolation over a fixed breakpoint table.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry i_voltage_code; a transfer happens
// at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_charge_percent (0..100); a
// transfer happens at a rising edge with o_valid high and i_stall low.
// Pipeline: 3 front stages for compare, segment select and multiply,
// 5 divider stages at one quotient bit each, 1 output register.
// Throughput: one code per cycle while o_stall is low.
// Codes below the first breakpoint give 0, codes above the last give 100.
// Reset (i_rst_n low, synchronous) empties every stage; o_valid drops.
// While i_stall holds the result, earlier empty stages keep filling; once
// all stages hold data, o_stall rises and no further code is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_voltage_to_percent_core #(
    parameter int BREAKPOINTS = bvp_pkg::BREAKPOINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bvp_pkg::CODE_W-1:0]  i_voltage_code,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bvp_pkg::PCT_W-1:0]   o_charge_percent
);

    logic                        front_rdy;
    logic                        front_vld;
    bvp_pkg::t_mul               front_data;
    logic                        div_rdy;
    logic                        div_vld;
    logic [bvp_pkg::PCT_W-1:0]   div_base;
    logic [bvp_pkg::QUO_W-1:0]   div_quo;
    logic                        out_rdy;
    logic                        r_out_vld;
    logic [bvp_pkg::PCT_W-1:0]   r_pct;
    logic [bvp_pkg::PCT_W-1:0]   n_pct;

    bvp_front #(
        .BREAKPOINTS (BREAKPOINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_valid),
        .i_code  (i_voltage_code),
        .o_rdy   (front_rdy),
        .o_vld   (front_vld),
        .o_data  (front_data),
        .i_rdy   (div_rdy)
    );

    bvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .i_data  (front_data),
        .o_rdy   (div_rdy),
        .o_vld   (div_vld),
        .o_base  (div_base),
        .o_quo   (div_quo),
        .i_rdy   (out_rdy)
    );

    assign out_rdy          = !r_out_vld || !i_stall;
    assign n_pct            = div_base + bvp_pkg::PCT_W'(div_quo);
    assign o_stall          = !front_rdy;
    assign o_valid          = r_out_vld;
    assign o_charge_percent = r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= div_vld;
        end
        if (out_rdy && div_vld) begin
            r_pct <= n_pct;
        end
    end

    `ASSERT_IMPL(a_pct_range, r_out_vld, r_pct <= bvp_pkg::PCT_W'(bvp_pkg::PCT_MAX), "percent above 100")
    `ASSERT_IMPL(a_quo_range, div_vld, div_quo <= bvp_pkg::QUO_W'(bvp_pkg::DP_MAX), "quotient exceeds segment step")
    `ASSERT_IMPL(a_stall_full, o_stall, r_out_vld && i_stall && div_vld && front_vld, "stall with a bubble in the pipe")
    `ASSERT_NEXT(a_hold_result, r_out_vld && i_stall, r_out_vld, "held result dropped")

endmodule

>>> test/tb_battery_voltage_to_percent_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_battery_voltage_to_percent_core
// Self-checking bench for the voltage-to-percent interpolator. Codes are sent
// over the valid/stall input channel, and a local interpolation over the
// package breakpoint tables predicts each percentage. Every output transfer
// is checked in order against the oldest prediction. The run covers the
// extremes and breakpoints, random codes with random idling on both sides,
// a full drain pause, and back-to-back streaming.
// ---------------------------------------------------------------------------
module tb_battery_voltage_to_percent_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [bvp_pkg::CODE_W-1:0] code;
        logic [bvp_pkg::PCT_W-1:0]  pct;
    } t_pct_expect;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic [bvp_pkg::CODE_W-1:0] i_voltage_code = '0;
    logic                       i_stall = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [bvp_pkg::PCT_W-1:0]  o_charge_percent;

    t_pct_expect pending_percent[$];
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          src_gaps_on = 1'b1;
    bit          stall_bursts_on = 1'b1;

    battery_voltage_to_percent_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_voltage_code   (i_voltage_code),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_charge_percent (o_charge_percent)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [bvp_pkg::PCT_W-1:0] interpolate_percent(
        input logic [bvp_pkg::CODE_W-1:0] code
    );
        int  pct;
        int  v0;
        int  dv;
        int  dx;
        int  p0;
        int  p1;
        bit  found;
        pct = bvp_pkg::PCT_TAB[bvp_pkg::TABLE_LEN-1];
        found = 1'b0;
        for (int k = 1; k < bvp_pkg::TABLE_LEN; k++) begin
            if (!found && code <= bvp_pkg::VOLT_TAB[k]) begin
                p0 = bvp_pkg::PCT_TAB[k-1];
                p1 = bvp_pkg::PCT_TAB[k];
                v0 = bvp_pkg::VOLT_TAB[k-1];
                dv = int'(bvp_pkg::VOLT_TAB[k]) - v0;
                dx = int'(code) - v0;
                pct = (dv <= 0) ? p0 : p0 + ((p1 - p0) * dx) / dv;
                found = 1'b1;
            end
        end
        if (pct < 0) pct = 0;
        if (pct > bvp_pkg::PCT_MAX) pct = bvp_pkg::PCT_MAX;
        return pct[bvp_pkg::PCT_W-1:0];
    endfunction

    function automatic logic [bvp_pkg::CODE_W-1:0] pick_code();
        int sel;
        int bp;
        int c;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            c = $urandom_range(bvp_pkg::VOLT_TAB[0],
                               bvp_pkg::VOLT_TAB[bvp_pkg::TABLE_LEN-1]);
        end else if (sel < 80) begin
            bp = $urandom_range(0, bvp_pkg::TABLE_LEN - 1);
            c = int'(bvp_pkg::VOLT_TAB[bp]) + $urandom_range(0, 4) - 2;
        end else if (sel < 90) begin
            c = $urandom_range(0, bvp_pkg::VOLT_TAB[0] - 1);
        end else begin
            c = $urandom_range(0, 16'hFFFF);
        end
        return c[bvp_pkg::CODE_W-1:0];
    endfunction

    // Hold each code until it transfers; return at the following falling edge.
    task automatic send_code(input logic [bvp_pkg::CODE_W-1:0] code);
        int gap;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_voltage_code = code;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        while (pending_percent.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_code(16'h0000);
        send_code(16'hFFFF);
        send_code(bvp_pkg::VOLT_TAB[0] - 16'd1);
        for (int k = 0; k < bvp_pkg::TABLE_LEN; k++) send_code(bvp_pkg::VOLT_TAB[k]);
        send_code(bvp_pkg::VOLT_TAB[bvp_pkg::TABLE_LEN-1] + 16'd1);
        i_valid = 1'b0;
    endtask

    task automatic test_random_codes(input int count);
        for (int n = 0; n < count; n++) send_code(pick_code());
        i_valid = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_all_results();
        repeat ($urandom_range(1, 15)) @(negedge i_clk);
        for (int n = 0; n < 25; n++) send_code(pick_code());
        i_valid = 1'b0;
    endtask

    task automatic test_streaming(input int count);
        src_gaps_on = 1'b0;
        stall_bursts_on = 1'b0;
        for (int n = 0; n < count; n++) send_code(pick_code());
        i_valid = 1'b0;
    endtask

    // Stall the result channel in random bursts.
    always @(negedge i_clk) begin
        if (!stall_bursts_on) stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        i_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    always @(posedge i_clk) begin
        t_pct_expect exp_item;
        if (i_rst_n && i_valid && !o_stall) begin
            exp_item.code = i_voltage_code;
            exp_item.pct = interpolate_percent(i_voltage_code);
            pending_percent.push_back(exp_item);
            n_sent++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (pending_percent.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result %0d at %0t", o_charge_percent, $realtime);
            end else begin
                exp_item = pending_percent.pop_front();
                if (o_charge_percent !== exp_item.pct) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch code %h: expected %0d, got %0d",
                                 exp_item.code, exp_item.pct, o_charge_percent);
                end
            end
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_battery_voltage_to_percent_core failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_codes(700);
        test_drain_pause();
        test_streaming(200);
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        n_errors += pending_percent.size();
        $display("Sent %0d codes: extremes, every breakpoint, random segments, drain pause,",
                 n_sent);
        $display("and back-to-back streaming; %0d results checked, %0d errors",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("tb_battery_voltage_to_percent_core passed");
        end else begin
            $display("tb_battery_voltage_to_percent_core failed");
        end
        $finish;
    end

endmodule
